// ===== src/wthit_pkg.sv =====
// shared types and constants for the window table hit test block
package wthit_pkg;

  typedef enum logic [2:0] {
    ACT_CREATE    = 3'd0,
    ACT_DESTROY   = 3'd1,
    ACT_MAP       = 3'd2,
    ACT_UNMAP     = 3'd3,
    ACT_CONFIGURE = 3'd4,
    ACT_SET_Z     = 3'd5,
    ACT_LOOKUP    = 3'd6,
    ACT_HIT_TEST  = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_ZERO_SIZE = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_APPLY,
    BK_REPORT
  } back_state_e;

  typedef struct packed {
    logic [2:0]         action;
    logic [31:0]        win_id;
    logic [31:0]        parent_id;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        width;
    logic [15:0]        height;
    logic [31:0]        ev_select;
    logic [31:0]        bg_colour;
    logic signed [31:0] z_value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [31:0]        result_id;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic [15:0]        out_width;
    logic [15:0]        out_height;
    logic               out_mapped;
    logic signed [31:0] out_z;
  } out_word_t;

  // classified command passed from front to back
  typedef struct packed {
    in_word_t word;
    logic     reject;
  } cmd_t;

  // slot record kept in memory
  typedef struct packed {
    logic               used;
    logic [31:0]        id;
    logic [31:0]        parent;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        w;
    logic [15:0]        h;
    logic [31:0]        mask;
    logic [31:0]        bg;
    logic               mapped;
    logic               dirty;
    logic signed [31:0] z;
  } slot_t;

  localparam int unsigned SlotWidth = $bits(slot_t);

endpackage

// ===== src/wthit_if.sv =====
// valid/ready channel interfaces for input and result words
interface wthit_in_if;
  import wthit_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface wthit_out_if;
  import wthit_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/window_table_hit_test_top.sv =====
// top level of the window table hit test block
// Each action word but a rejected zero-size create walks the window table one
// slot per cycle through the table RAM read port; lookups and window actions
// stop at the first matching slot, creates at the first free one, hit tests
// always read every slot. A two-word queue in front lets the next word be
// taken while one is in progress and a result waits.
module window_table_hit_test_top import wthit_pkg::*; #(
  parameter int unsigned NUM_WINDOWS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  wthit_in_if.sink    in_i,
  wthit_out_if.source out_o
);
  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  wthit_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  wthit_back #(.NumWindows(NUM_WINDOWS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .out_o      (out_o)
  );
endmodule

// ===== src/wthit_ram.sv =====
// generic single-port-write, single-read RAM with registered read
module wthit_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== src/wthit_front.sv =====
// front end: accepts words, screens zero-size creates, feeds a two-entry queue
module wthit_front import wthit_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  wthit_in_if.sink    in_i,
  output logic        cmd_valid_o,
  output cmd_t        cmd_o,
  input  logic        cmd_pop_i
);
  cmd_t       fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push;
  cmd_t       cmd_in;

  assign in_i.ready  = (count_q != 2'd2);
  assign push        = in_i.valid && in_i.ready;
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];

  // classify: create with zero size is rejected up front
  always_comb begin
    cmd_in.word   = in_i.data;
    cmd_in.reject = (in_i.data.action == ACT_CREATE) &&
                    ((in_i.data.width == '0) || (in_i.data.height == '0));
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (cmd_pop_i) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + 2'(push) - 2'(cmd_pop_i);
    end
  end
endmodule

// ===== src/wthit_back.sv =====
// back end: scans the slot table one slot a cycle and carries out the action
module wthit_back import wthit_pkg::*; #(
  parameter int unsigned NumWindows = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  cmd_t        cmd_i,
  output logic        cmd_pop_o,
  wthit_out_if.source out_o
);
  localparam int unsigned IdxW = $clog2(NumWindows);

  back_state_e      state_q, state_d;
  cmd_t             cmd_q;
  logic [IdxW:0]    scan_q;      // read address issued, one wider to hold the end
  logic             rd_vld_q;    // rdata valid for slot rd_idx_q
  logic [IdxW-1:0]  rd_idx_q;
  logic             found_q;
  logic [IdxW-1:0]  found_idx_q;
  slot_t            found_rec_q;
  logic signed [31:0] next_z_q;
  logic [NumWindows-1:0] used_q;  // valid bits: slot not used reads as zero
  logic             out_vld_q;
  out_word_t        out_q;
  out_word_t        out_d;

  logic             we;
  logic [IdxW-1:0]  waddr;
  slot_t            wdata, rdata_raw, rec;
  logic             scan_done;
  logic             match, hit, in_x, in_y;
  logic signed [17:0] px, py, x0, y0;

  wthit_ram #(.Width(SlotWidth), .Depth(NumWindows)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(scan_q[IdxW-1:0]),
    .rdata_o(rdata_raw)
  );

  // unused slots read as cleared
  always_comb begin
    rec = used_q[rd_idx_q] ? rdata_raw : '0;
  end

  // compare of the slot read this cycle
  always_comb begin
    px = 18'(cmd_q.word.pos_x);
    py = 18'(cmd_q.word.pos_y);
    x0 = 18'(rec.x);
    y0 = 18'(rec.y);
    in_x = (px >= x0) && (px < x0 + $signed({2'b00, rec.w}));
    in_y = (py >= y0) && (py < y0 + $signed({2'b00, rec.h}));
    match = rec.used && (rec.id == cmd_q.word.win_id);
    hit   = rec.used && rec.mapped && in_x && in_y && (rec.z > -32'sd1) &&
            (!found_q || (rec.z > found_rec_q.z));
  end

  assign scan_done = rd_vld_q && (32'(rd_idx_q) == NumWindows - 1);
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE:   if (cmd_valid_i) state_d = cmd_i.reject ? BK_REPORT : BK_SCAN;
      BK_SCAN:   if (scan_done || (rd_vld_q && found_q &&
                     cmd_q.word.action != ACT_HIT_TEST)) state_d = BK_APPLY;
      BK_APPLY:  state_d = BK_REPORT;
      BK_REPORT: if (!out_vld_q || out_o.ready) state_d = BK_IDLE;
      default:   state_d = BK_IDLE;
    endcase
  end

  // outputs: pop and table write
  always_comb begin
    cmd_pop_o = (state_q == BK_IDLE) && cmd_valid_i;
    we    = 1'b0;
    waddr = found_idx_q;
    wdata = found_rec_q;
    if (state_q == BK_APPLY && found_q) begin
      case (cmd_q.word.action)
        ACT_CREATE: begin
          we = 1'b1;
          wdata = '0;
          wdata.used   = 1'b1;
          wdata.id     = cmd_q.word.win_id;
          wdata.parent = cmd_q.word.parent_id;
          wdata.x      = cmd_q.word.pos_x;
          wdata.y      = cmd_q.word.pos_y;
          wdata.w      = cmd_q.word.width;
          wdata.h      = cmd_q.word.height;
          wdata.mask   = cmd_q.word.ev_select;
          wdata.bg     = cmd_q.word.bg_colour;
          wdata.z      = next_z_q;
        end
        ACT_MAP:   begin we = 1'b1; wdata.mapped = 1'b1; end
        ACT_UNMAP: begin we = 1'b1; wdata.mapped = 1'b0; end
        ACT_CONFIGURE: begin
          we = 1'b1;
          wdata.x = cmd_q.word.pos_x;
          wdata.y = cmd_q.word.pos_y;
          wdata.w = cmd_q.word.width;
          wdata.h = cmd_q.word.height;
          wdata.dirty = 1'b1;
        end
        ACT_SET_Z: begin we = 1'b1; wdata.z = cmd_q.word.z_value; end
        default: ;
      endcase
    end
  end

  // result word
  always_comb begin
    out_d = '0;
    if (cmd_q.reject) begin
      out_d.status = ST_ZERO_SIZE;
    end else if (!found_q) begin
      out_d.status = (cmd_q.word.action == ACT_CREATE) ? ST_FULL : ST_NOT_FOUND;
    end else begin
      out_d.status = ST_OK;
      if (cmd_q.word.action == ACT_LOOKUP || cmd_q.word.action == ACT_HIT_TEST) begin
        out_d.result_id  = found_rec_q.id;
        out_d.out_x      = found_rec_q.x;
        out_d.out_y      = found_rec_q.y;
        out_d.out_width  = found_rec_q.w;
        out_d.out_height = found_rec_q.h;
        out_d.out_mapped = found_rec_q.mapped;
        out_d.out_z      = found_rec_q.z;
      end
    end
  end

  // sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      scan_q    <= '0;
      rd_vld_q  <= 1'b0;
      found_q   <= 1'b0;
      next_z_q  <= '0;
      used_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == BK_REPORT && (!out_vld_q || out_o.ready)) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        BK_IDLE: begin
          scan_q   <= '0;
          rd_vld_q <= 1'b0;
          found_q  <= 1'b0;
        end
        BK_SCAN: begin
          rd_vld_q <= (32'(scan_q) < NumWindows);
          if (32'(scan_q) < NumWindows) scan_q <= scan_q + 1'b1;
          if (rd_vld_q && !(found_q && cmd_q.word.action != ACT_HIT_TEST)) begin
            case (cmd_q.word.action)
              ACT_CREATE:   if (!rec.used) found_q <= 1'b1;
              ACT_HIT_TEST: if (hit) found_q <= 1'b1;
              default:      if (match) found_q <= 1'b1;
            endcase
          end
        end
        BK_APPLY: begin
          if (found_q) begin
            case (cmd_q.word.action)
              ACT_CREATE: begin
                used_q[found_idx_q] <= 1'b1;
                next_z_q <= next_z_q + 32'sd1;
              end
              ACT_DESTROY: used_q[found_idx_q] <= 1'b0;
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_idx_q <= scan_q[IdxW-1:0];
    if (state_q == BK_IDLE && cmd_valid_i) cmd_q <= cmd_i;
    if (state_q == BK_SCAN && rd_vld_q &&
        !(found_q && cmd_q.word.action != ACT_HIT_TEST)) begin
      if ((cmd_q.word.action == ACT_CREATE && !rec.used) ||
          (cmd_q.word.action == ACT_HIT_TEST && hit) ||
          (cmd_q.word.action != ACT_CREATE && cmd_q.word.action != ACT_HIT_TEST
           && match)) begin
        found_idx_q <= rd_idx_q;
        found_rec_q <= rec;
      end
    end
    // result word register
    if (state_q == BK_REPORT && (!out_vld_q || out_o.ready)) begin
      out_q <= out_d;
    end
  end
endmodule

// ===== sim/tb.sv =====
// testbench for the window table hit test block: class scoreboard and plain stimulus tasks
module tb;
  import wthit_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumWin = 64;
  localparam longint CycleLimit = 2000000;

  // window table mirror and expected result queue
  class window_table_sb;
    slot_t     tbl[NumWin];
    logic [31:0] z_next;
    out_word_t pending[$];
    int        mismatches;
    int        shown;

    function void clear_all();
      foreach (tbl[i]) tbl[i] = '0;
      z_next = '0;
      pending.delete();
      mismatches = 0;
      shown = 0;
    endfunction

    function int find_id(logic [31:0] id);
      for (int i = 0; i < NumWin; i++)
        if (tbl[i].used && tbl[i].id == id) return i;
      return -1;
    endfunction

    function out_word_t show(int i);
      out_word_t r;
      r = '0;
      r.status = ST_OK;
      r.result_id = tbl[i].id;
      r.out_x = tbl[i].x;
      r.out_y = tbl[i].y;
      r.out_width = tbl[i].w;
      r.out_height = tbl[i].h;
      r.out_mapped = tbl[i].mapped;
      r.out_z = tbl[i].z;
      return r;
    endfunction

    // apply one accepted word to the mirror and queue its result
    function void note_word(in_word_t w);
      out_word_t r;
      int i;
      int best;
      longint bz;
      longint x0;
      longint y0;
      r = '0;
      if (w.action == ACT_CREATE) begin
        i = -1;
        for (int k = 0; k < NumWin; k++)
          if (!tbl[k].used && i < 0) i = k;
        if (w.width == 0 || w.height == 0) r.status = ST_ZERO_SIZE;
        else if (i < 0) r.status = ST_FULL;
        else begin
          tbl[i] = '0;
          tbl[i].used = 1'b1;
          tbl[i].id = w.win_id;
          tbl[i].parent = w.parent_id;
          tbl[i].x = w.pos_x;
          tbl[i].y = w.pos_y;
          tbl[i].w = w.width;
          tbl[i].h = w.height;
          tbl[i].mask = w.ev_select;
          tbl[i].bg = w.bg_colour;
          tbl[i].z = z_next;
          z_next = z_next + 32'd1;
          r.status = ST_OK;
        end
      end else if (w.action == ACT_HIT_TEST) begin
        best = -1;
        bz = -1;
        for (int k = 0; k < NumWin; k++) begin
          if (tbl[k].used && tbl[k].mapped) begin
            x0 = longint'(tbl[k].x);
            y0 = longint'(tbl[k].y);
            if (longint'(w.pos_x) >= x0 && longint'(w.pos_x) < x0 + longint'(tbl[k].w) &&
                longint'(w.pos_y) >= y0 && longint'(w.pos_y) < y0 + longint'(tbl[k].h) &&
                longint'(tbl[k].z) > bz) begin
              bz = longint'(tbl[k].z);
              best = k;
            end
          end
        end
        if (best < 0) r.status = ST_NOT_FOUND;
        else r = show(best);
      end else begin
        i = find_id(w.win_id);
        if (i < 0) r.status = ST_NOT_FOUND;
        else begin
          r.status = ST_OK;
          case (action_e'(w.action))
            ACT_DESTROY: tbl[i] = '0;
            ACT_MAP: tbl[i].mapped = 1'b1;
            ACT_UNMAP: tbl[i].mapped = 1'b0;
            ACT_CONFIGURE: begin
              tbl[i].x = w.pos_x;
              tbl[i].y = w.pos_y;
              tbl[i].w = w.width;
              tbl[i].h = w.height;
              tbl[i].dirty = 1'b1;
            end
            ACT_SET_Z: tbl[i].z = w.z_value;
            default: r = show(i);
          endcase
        end
      end
      pending.push_back(r);
    endfunction

    // compare one result word with the oldest expectation
    function void check_word(out_word_t got);
      out_word_t exp_w;
      if (pending.size() == 0) begin
        mismatches++;
        if (shown < 10) begin
          shown++;
          $display("unexpected result word %h", got);
        end
        return;
      end
      exp_w = pending.pop_front();
      if (got !== exp_w) begin
        mismatches++;
        if (shown < 10) begin
          shown++;
          $display("mismatch: exp st=%0d id=%h x=%0d y=%0d w=%0d h=%0d m=%0b z=%0d",
                   exp_w.status, exp_w.result_id, exp_w.out_x, exp_w.out_y,
                   exp_w.out_width, exp_w.out_height, exp_w.out_mapped, exp_w.out_z);
          $display("          got st=%0d id=%h x=%0d y=%0d w=%0d h=%0d m=%0b z=%0d",
                   got.status, got.result_id, got.out_x, got.out_y,
                   got.out_width, got.out_height, got.out_mapped, got.out_z);
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  wthit_in_if  in_ch();
  wthit_out_if out_ch();

  window_table_hit_test_top #(.NUM_WINDOWS(NumWin)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  window_table_sb sb;
  int  send_idle_pct;
  int  recv_stall_pct;
  int  hold_cycles;
  bit  timed_out;
  longint cycles;
  logic [31:0] id_pool[8];

  // clock and cycle limit
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // long receiver hold-off count
  always @(posedge clk_i) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  // receiver side: random stall plus long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) sb.check_word(out_ch.data);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // present one word, with random idle cycles ahead of it
  task automatic send_word(in_word_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_word(w);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  function automatic in_word_t make_word(action_e a, logic [31:0] id,
                                         int x, int y, int wd, int ht);
    in_word_t w;
    w.action = a;
    w.win_id = id;
    w.parent_id = $urandom;
    w.pos_x = 16'(x);
    w.pos_y = 16'(y);
    w.width = 16'(wd);
    w.height = 16'(ht);
    w.ev_select = $urandom;
    w.bg_colour = $urandom;
    w.z_value = $urandom;
    return w;
  endfunction

  function automatic logic signed [15:0] rnd_coord();
    case ($urandom_range(3))
      0: return 16'(16'sh8000 + $urandom_range(3));
      1: return 16'(16'sh7fff - $urandom_range(3));
      default: return 16'($urandom_range(400) - 200);
    endcase
  endfunction

  // random word, mostly on a small pool of ids so actions find windows
  function automatic in_word_t rnd_word();
    in_word_t w;
    logic [31:0] id;
    action_e a;
    id = ($urandom_range(9) == 0) ? $urandom : id_pool[$urandom_range(7)];
    a = action_e'($urandom_range(7));
    if ($urandom_range(3) == 0) a = ACT_HIT_TEST;
    w = make_word(a, id, rnd_coord(), rnd_coord(),
                  ($urandom_range(15) == 0) ? 16'($urandom) : 16'($urandom_range(300)),
                  ($urandom_range(15) == 0) ? 16'($urandom) : 16'($urandom_range(300)));
    if ($urandom_range(3) != 0)
      w.z_value = ($urandom_range(4) == 0) ? -$urandom_range(3) : $urandom_range(50);
    return w;
  endfunction

  initial begin
    in_word_t w;
    sb = new();
    sb.clear_all();
    cycles = 0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    foreach (id_pool[i]) id_pool[i] = (i == 0) ? 32'hffffffff : (i == 1) ? 32'h0 : $urandom;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, zero sizes, extremes, every action
    send_word(make_word(ACT_HIT_TEST, 0, 0, 0, 0, 0));
    send_word(make_word(ACT_LOOKUP, 32'hffffffff, 0, 0, 0, 0));
    send_word(make_word(ACT_CREATE, 1, 0, 0, 0, 5));
    send_word(make_word(ACT_CREATE, 1, 0, 0, 5, 0));
    send_word(make_word(ACT_CREATE, 32'hffffffff, 16'sh8000, 16'sh8000, 16'hffff, 16'hffff));
    send_word(make_word(ACT_CREATE, 0, 16'sh7fff, 16'sh7fff, 16'hffff, 16'hffff));
    send_word(make_word(ACT_CREATE, 0, 10, 10, 1, 1));
    send_word(make_word(ACT_MAP, 32'hffffffff, 0, 0, 0, 0));
    send_word(make_word(ACT_MAP, 0, 0, 0, 0, 0));
    send_word(make_word(ACT_HIT_TEST, 0, 16'sh7fff, 16'sh7fff, 0, 0));
    send_word(make_word(ACT_HIT_TEST, 0, 16'sh8000, 16'sh8000, 0, 0));
    send_word(make_word(ACT_HIT_TEST, 0, 16'sh7ffe, 16'sh7fff, 0, 0));
    w = make_word(ACT_SET_Z, 32'hffffffff, 0, 0, 0, 0);
    w.z_value = -1;
    send_word(w);
    send_word(make_word(ACT_HIT_TEST, 0, 16'sh8000, 16'sh8000, 0, 0));
    w.z_value = 32'sh7fffffff;
    send_word(w);
    send_word(make_word(ACT_HIT_TEST, 0, 16'sh7fff, 16'sh7fff, 0, 0));
    send_word(make_word(ACT_CONFIGURE, 0, -5, -5, 0, 0));
    send_word(make_word(ACT_LOOKUP, 0, 0, 0, 0, 0));
    send_word(make_word(ACT_UNMAP, 32'hffffffff, 0, 0, 0, 0));
    send_word(make_word(ACT_LOOKUP, 32'hffffffff, 0, 0, 0, 0));
    send_word(make_word(ACT_DESTROY, 0, 0, 0, 0, 0));
    send_word(make_word(ACT_LOOKUP, 0, 0, 0, 0, 0));
    send_word(make_word(ACT_DESTROY, 12345, 0, 0, 0, 0));
    // fill the table to force the full status
    for (int i = 0; i < NumWin + 2; i++)
      send_word(make_word(ACT_CREATE, 100 + i, i, i, 3, 3));
    // long receiver hold-off while the sender keeps offering
    hold_cycles = 600;
    for (int i = 0; i < 6; i++) send_word(make_word(ACT_HIT_TEST, 0, i, i, 0, 0));
    drain();
    for (int i = 0; i < NumWin; i++) send_word(make_word(ACT_DESTROY, 100 + i, 0, 0, 0, 0));
    send_word(make_word(ACT_DESTROY, 32'hffffffff, 0, 0, 0, 0));
    drain();

    // random phases with varying idle and stall
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        3: begin send_idle_pct = 19; recv_stall_pct = 19; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int n = 0; n < 128; n++) send_word(rnd_word());
      drain();
    end

    drain();
    repeat (200) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
